// File: design/byte_fifo_with_search_defines.svh
// Assertion macros used by the byte FIFO with search top-level design file.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef BYTE_FIFO_WITH_SEARCH_DEFINES_SVH
`define BYTE_FIFO_WITH_SEARCH_DEFINES_SVH

`ifndef ASSERT_OFF
`define BFS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define BFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`define BFS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant check failed");
`else
`define BFS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BFS_ASSERT_NEXT(label, clk, rst, ante, cons)
`define BFS_ASSERT_ALWAYS(label, clk, rst, cond)
`endif

`endif

// File: design/bfs_pkg.sv
// Types shared by the byte FIFO with search: request codes and sequencer states.
// Depends on nothing.
package bfs_pkg;

   typedef enum logic [1:0] {
      ACT_PUSH   = 2'd0,
      ACT_POP    = 2'd1,
      ACT_SEARCH = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_EXEC      = 6'b000010,
      ST_POP_WAIT  = 6'b000100,
      ST_SCAN      = 6'b001000,
      ST_HEAD_RD   = 6'b010000,
      ST_HEAD_WAIT = 6'b100000
   } state_type;

endpackage

// File: design/bfs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bfs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/byte_fifo_with_search.sv
// Top level of the byte FIFO with search: sequencer, pointers and result registers.
// Depends on bfs_pkg, bfs_ram and byte_fifo_with_search_defines.svh.
//
// Usage: raise start with req_action and req_data_byte while busy is low; the
// beat is taken at that clock edge and busy stays high until the result is out.
// Actions are push, pop, search and clear. Each request gives exactly one result
// beat, shown for one cycle with rsp_strobe high; the receiver cannot stall it.
// rsp_head_byte and rsp_fill_count describe the queue after the request.
// After the accepting edge the sequencer runs EXEC, then POP_WAIT for a pop or
// SCAN for a search when the queue is not empty, then HEAD_RD and HEAD_WAIT,
// and raises the strobe. The search walks the held bytes through the one RAM
// read port, one compare per cycle, so a search lasts longer the fuller the queue.
// A new request may be taken in the same cycle as the strobe.
// Reset empties the queue; a head read of the empty queue is masked to zero.
module byte_fifo_with_search #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_action,
   input  logic [7:0]              req_data_byte,
   output logic                    rsp_strobe,
   output logic                    rsp_ok,
   output logic [7:0]              rsp_popped_byte,
   output logic [7:0]              rsp_head_byte,
   output logic [6:0]              rsp_fill_count
);
   import bfs_pkg::*;
`include "byte_fifo_with_search_defines.svh"

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastSlot = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCount = CntW'(DEPTH);

   state_type         state_ff, state_in;
   action_type        act_ff, act_in;
   logic [7:0]        data_ff, data_in;
   logic [PtrW-1:0]   rd_ff, rd_in;
   logic [PtrW-1:0]   wr_ff, wr_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              ok_ff, ok_in;
   logic [7:0]        popped_ff, popped_in;
   logic [7:0]        head_ff, head_in;
   logic [PtrW-1:0]   scan_ptr_ff, scan_ptr_in;
   logic [CntW-1:0]   scan_cnt_ff, scan_cnt_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic              strobe_ff, strobe_in;

   logic              ram_we;
   logic [PtrW-1:0]   ram_waddr;
   logic              ram_re;
   logic [PtrW-1:0]   ram_raddr;
   logic [7:0]        ram_rdata;
   logic              accept;

   function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] s);
      return (s == LastSlot) ? '0 : s + 1'b1;
   endfunction

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      data_in     = data_ff;
      rd_in       = rd_ff;
      wr_in       = wr_ff;
      cnt_in      = cnt_ff;
      ok_in       = ok_ff;
      popped_in   = popped_ff;
      head_in     = head_ff;
      scan_ptr_in = scan_ptr_ff;
      scan_cnt_in = scan_cnt_ff;
      cmp_vld_in  = 1'b0;
      strobe_in   = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = wr_ff;
      ram_re      = 1'b0;
      ram_raddr   = rd_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in    = action_type'(req_action);
               data_in   = req_data_byte;
               ok_in     = 1'b0;
               popped_in = '0;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_HEAD_RD;
            unique case (act_ff)
               ACT_PUSH: begin
                  if (cnt_ff < FullCount) begin
                     ram_we = 1'b1;
                     wr_in  = next_slot(wr_ff);
                     cnt_in = cnt_ff + 1'b1;
                     ok_in  = 1'b1;
                  end
               end
               ACT_POP: begin
                  if (cnt_ff != '0) begin
                     ram_re   = 1'b1;
                     state_in = ST_POP_WAIT;
                  end
               end
               ACT_SEARCH: begin
                  if (cnt_ff != '0) begin
                     scan_ptr_in = rd_ff;
                     scan_cnt_in = '0;
                     state_in    = ST_SCAN;
                  end
               end
               ACT_CLEAR: begin
                  rd_in  = '0;
                  wr_in  = '0;
                  cnt_in = '0;
                  ok_in  = 1'b1;
               end
               default: begin
                  state_in = ST_HEAD_RD;
               end
            endcase
         end
         ST_POP_WAIT: begin
            popped_in = ram_rdata;
            rd_in     = next_slot(rd_ff);
            cnt_in    = cnt_ff - 1'b1;
            ok_in     = 1'b1;
            state_in  = ST_HEAD_RD;
         end
         ST_SCAN: begin
            if (cmp_vld_ff && (ram_rdata == data_ff)) begin
               ok_in = 1'b1;
            end
            if (scan_cnt_ff < cnt_ff) begin
               ram_re      = 1'b1;
               ram_raddr   = scan_ptr_ff;
               scan_ptr_in = next_slot(scan_ptr_ff);
               scan_cnt_in = scan_cnt_ff + 1'b1;
               cmp_vld_in  = 1'b1;
            end else if (!cmp_vld_ff) begin
               state_in = ST_HEAD_RD;
            end
         end
         ST_HEAD_RD: begin
            ram_re   = 1'b1;
            state_in = ST_HEAD_WAIT;
         end
         ST_HEAD_WAIT: begin
            head_in   = (cnt_ff != '0) ? ram_rdata : '0;
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_ff      <= '0;
         wr_ff      <= '0;
         cnt_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_ff      <= rd_in;
         wr_ff      <= wr_in;
         cnt_ff     <= cnt_in;
         cmp_vld_ff <= cmp_vld_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      data_ff     <= data_in;
      ok_ff       <= ok_in;
      popped_ff   <= popped_in;
      head_ff     <= head_in;
      scan_ptr_ff <= scan_ptr_in;
      scan_cnt_ff <= scan_cnt_in;
   end

   bfs_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (data_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_strobe      = strobe_ff;
   assign rsp_ok          = ok_ff;
   assign rsp_popped_byte = popped_ff;
   assign rsp_head_byte   = head_ff;
   assign rsp_fill_count  = 7'(cnt_ff);

   `BFS_ASSERT_ALWAYS(a_count_bound, clock, reset, cnt_ff <= FullCount)
   `BFS_ASSERT_IMPLY(a_empty_ptrs, clock, reset, cnt_ff == '0, rd_ff == wr_ff)
   `BFS_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == ST_EXEC)
   `BFS_ASSERT_IMPLY(a_empty_head, clock, reset, strobe_ff && (cnt_ff == '0), head_ff == '0)

endmodule

// File: bench/testbench.sv
// Testbench for byte_fifo_with_search: drives push, pop, search and clear beats
// and checks every result beat against a queue-based prediction of the FIFO.
// Depends on bfs_pkg and the byte_fifo_with_search RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bfs_pkg::*;

   localparam int unsigned DEPTH = 64;
   localparam int unsigned RANDOM_BEATS = 700;

   typedef struct packed {
      logic       ok;
      logic [7:0] popped_byte;
      logic [7:0] head_byte;
      logic [6:0] fill_count;
   } fifo_result_type;

   class fifo_scoreboard;
      bit [7:0]        held_bytes[$];
      fifo_result_type expected_results[$];
      int unsigned     fails;

      function void note_request(action_type act, bit [7:0] value);
         fifo_result_type want;
         want = '0;
         case (act)
            ACT_PUSH: begin
               if (held_bytes.size() < DEPTH) begin
                  held_bytes.push_back(value);
                  want.ok = 1'b1;
               end
            end
            ACT_POP: begin
               if (held_bytes.size() != 0) begin
                  want.popped_byte = held_bytes.pop_front();
                  want.ok = 1'b1;
               end
            end
            ACT_SEARCH: begin
               foreach (held_bytes[i])
                  if (held_bytes[i] == value)
                     want.ok = 1'b1;
            end
            default: begin
               held_bytes.delete();
               want.ok = 1'b1;
            end
         endcase
         if (held_bytes.size() != 0)
            want.head_byte = held_bytes[0];
         want.fill_count = 7'(held_bytes.size());
         expected_results.push_back(want);
      endfunction

      function void check_result(fifo_result_type got);
         fifo_result_type want;
         if (expected_results.size() == 0) begin
            $error("result beat with no request outstanding");
            fails++;
            return;
         end
         want = expected_results.pop_front();
         if (got.ok !== want.ok) begin
            $error("ok mismatch: expected %0d, got %0d", want.ok, got.ok);
            fails++;
         end
         if (got.popped_byte !== want.popped_byte) begin
            $error("popped_byte mismatch: expected %0d, got %0d",
                   want.popped_byte, got.popped_byte);
            fails++;
         end
         if (got.head_byte !== want.head_byte) begin
            $error("head_byte mismatch: expected %0d, got %0d",
                   want.head_byte, got.head_byte);
            fails++;
         end
         if (got.fill_count !== want.fill_count) begin
            $error("fill_count mismatch: expected %0d, got %0d",
                   want.fill_count, got.fill_count);
            fails++;
         end
      endfunction

      function bit [7:0] search_value();
         if (held_bytes.size() != 0 && $urandom_range(3) != 0)
            return held_bytes[$urandom_range(held_bytes.size() - 1)];
         return 8'($urandom);
      endfunction
   endclass

   logic       clock;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic [1:0] req_action = ACT_PUSH;
   logic [7:0] req_data_byte = 8'h00;
   logic       busy;
   logic       rsp_strobe;
   logic       rsp_ok;
   logic [7:0] rsp_popped_byte;
   logic [7:0] rsp_head_byte;
   logic [6:0] rsp_fill_count;

   fifo_scoreboard fifo_tracker = new();
   int unsigned    beats_sent;
   int unsigned    idle_percent;

   byte_fifo_with_search #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_data_byte(req_data_byte),
      .rsp_strobe(rsp_strobe),
      .rsp_ok(rsp_ok),
      .rsp_popped_byte(rsp_popped_byte),
      .rsp_head_byte(rsp_head_byte),
      .rsp_fill_count(rsp_fill_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1)
            fifo_tracker.check_result(fifo_result_type'{rsp_ok, rsp_popped_byte,
                                      rsp_head_byte, rsp_fill_count});
         if (start === 1'b1 && busy === 1'b0)
            fifo_tracker.note_request(action_type'(req_action), req_data_byte);
      end
   end

   task automatic idle_gap();
      int unsigned gap;
      gap = ($urandom_range(9) == 0) ? $urandom_range(70, 9) : $urandom_range(8, 1);
      start <= 1'b0;
      req_action <= 2'($urandom);
      req_data_byte <= 8'($urandom);
      repeat (gap) @(posedge clock);
   endtask

   task automatic send_beat(action_type act, bit [7:0] value);
      if ($urandom_range(99) < idle_percent)
         idle_gap();
      start <= 1'b1;
      req_action <= act;
      req_data_byte <= value;
      do @(posedge clock); while (busy !== 1'b0);
      beats_sent++;
   endtask

   initial begin
      int unsigned phase_idle[3] = '{0, 55, 24};
      int unsigned target;
      int unsigned pick;
      int unsigned roll;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      idle_percent = 0;

      // Edge values, the newest slot in a search, emptying by pop and by clear.
      send_beat(ACT_SEARCH, 8'h00);
      send_beat(ACT_POP, 8'hFF);
      send_beat(ACT_PUSH, 8'h00);
      send_beat(ACT_PUSH, 8'hFF);
      send_beat(ACT_SEARCH, 8'hFF);
      send_beat(ACT_SEARCH, 8'h00);
      send_beat(ACT_SEARCH, 8'h5A);
      send_beat(ACT_POP, 8'h00);
      send_beat(ACT_POP, 8'h00);
      send_beat(ACT_POP, 8'h00);
      send_beat(ACT_SEARCH, 8'h00);
      send_beat(ACT_PUSH, 8'h80);
      send_beat(ACT_PUSH, 8'h01);
      send_beat(ACT_CLEAR, 8'hFF);
      send_beat(ACT_POP, 8'h00);
      send_beat(ACT_SEARCH, 8'h80);
      send_beat(ACT_CLEAR, 8'h00);
      send_beat(ACT_PUSH, 8'h7F);
      send_beat(ACT_PUSH, 8'hAA);
      send_beat(ACT_SEARCH, 8'hAA);

      foreach (phase_idle[p]) begin
         idle_percent = phase_idle[p];
         target = beats_sent + RANDOM_BEATS / 3;
         while (beats_sent < target) begin
            pick = $urandom_range(9);
            if (pick < 2) begin
               repeat (DEPTH + 2 - fifo_tracker.held_bytes.size()) begin
                  send_beat(ACT_PUSH, 8'($urandom));
                  if ($urandom_range(7) == 0)
                     send_beat(ACT_SEARCH, fifo_tracker.search_value());
               end
               send_beat(ACT_SEARCH, fifo_tracker.held_bytes[$]);
            end else if (pick == 2) begin
               repeat (fifo_tracker.held_bytes.size() + 2) begin
                  send_beat(ACT_POP, 8'($urandom));
                  if ($urandom_range(7) == 0)
                     send_beat(ACT_SEARCH, fifo_tracker.search_value());
               end
            end else if (pick == 3) begin
               send_beat(ACT_CLEAR, 8'($urandom));
            end else begin
               repeat ($urandom_range(30, 10)) begin
                  roll = $urandom_range(99);
                  if (roll < 40)
                     send_beat(ACT_PUSH, 8'($urandom));
                  else if (roll < 70)
                     send_beat(ACT_POP, 8'($urandom));
                  else if (roll < 97)
                     send_beat(ACT_SEARCH, fifo_tracker.search_value());
                  else
                     send_beat(ACT_CLEAR, 8'($urandom));
               end
            end
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (fifo_tracker.expected_results.size() != 0)
         @(posedge clock);
      repeat (DEPTH + 10) @(posedge clock);
      if (fifo_tracker.fails == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
